/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is asserted.
`define HSE_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Clocked property that is also checked during reset.
`define HSE_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

/* sv/hse_pkg.sv */
// Shared types and constants of the Huffman symbol encoder and packer.
package hse_pkg;

    // Request opcodes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    // Fixed field widths
    localparam int CODE_FIELD_W = 16;
    localparam int LEN_W        = 5;
    localparam int PEND_W       = 7;
    localparam int BYTE_W       = 8;
    localparam int TAIL_W       = 4;
    localparam int SYM_W        = 8;

    // Result queue depth (power of two)
    localparam int RES_FIFO_DEPTH = 8;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              last;
        logic [TAIL_W-1:0] tail_bits;
    } result_t;

    // Up to two results pushed per cycle; second only with first
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        result_t res0;
        result_t res1;
    } res_push_t;

endpackage

/* sv/hse_item_if.sv */
// Request channel: table writes, symbols to encode and flushes.
interface hse_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [7:0]  symbol;
    logic [15:0] code_bits;
    logic [4:0]  code_len;

    modport source (output valid, output op, output symbol, output code_bits,
                    output code_len, input ready);
    modport sink   (input valid, input op, input symbol, input code_bits,
                    input code_len, output ready);
endinterface

/* sv/hse_result_if.sv */
// Result channel: packed bytes and end-of-stream reports.
interface hse_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic [3:0] tail_bits;

    modport source (output valid, output out_byte, output byte_valid,
                    output last, output tail_bits, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input last, input tail_bits, output ready);
endinterface

/* sv/hse_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module hse_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/hse_result_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one.
module hse_result_fifo import hse_pkg::*; (
    input  logic                              clk,
    input  logic                              rst_n,
    input  res_push_t                         push,
    output logic [$clog2(RES_FIFO_DEPTH):0]   count,
    output logic                              out_valid,
    input  logic                              out_ready,
    output result_t                           out_res
);

    localparam int AW = $clog2(RES_FIFO_DEPTH);

    result_t         mem_reg [RES_FIFO_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;
    logic            pop;
    logic [1:0]      n_push;

    assign pop    = (count_reg != '0) && out_ready;
    assign n_push = {1'b0, push.valid0} + {1'b0, push.valid1};

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(n_push);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + (AW+1)'(n_push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, two write slots
    always_ff @(posedge clk)
    begin
        if (push.valid0)
        begin
            mem_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.valid1)
        begin
            mem_reg[wr_ptr_reg + AW'(1)] <= push.res1;
        end
    end

    assign count     = count_reg;
    assign out_valid = (count_reg != '0);
    assign out_res   = mem_reg[rd_ptr_reg];

endmodule

/* sv/huffman_symbol_encoder_packer.sv */
// Huffman encoder: code table lookup and MSB-first byte packing.
// A request's table entry is read into stage 1, and its packed bytes are then
// written into the result queue.
// Throughput: one request per cycle; one result per cycle leaves the 8-entry
// queue, and ready drops while it lacks room for two results per request.
// Reset (async, active low) clears all table entry valid bits at once, the
// pending bits, the stream flag and the result queue.
module huffman_symbol_encoder_packer import hse_pkg::*; #(
    parameter int MAX_CODE_LEN = 16,
    parameter int NUM_SYMBOLS  = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    hse_item_if.sink      item,
    hse_result_if.source  result
);

    localparam int CODE_W  = (MAX_CODE_LEN < CODE_FIELD_W) ? MAX_CODE_LEN : CODE_FIELD_W;
    localparam int SYM_AW  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int ENTRY_W = CODE_W + LEN_W;
    localparam int ACC_W   = PEND_W + CODE_W;
    localparam int TOT_W   = $clog2(ACC_W + 9);
    localparam int QAW     = $clog2(RES_FIFO_DEPTH);
    localparam logic [SYM_W:0]   NUM_SYM_L = (SYM_W+1)'(NUM_SYMBOLS);
    localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(CODE_W);

    // Request side
    logic                    item_acc;
    logic                    sym_in_range;
    logic                    wr_ok;
    logic [CODE_FIELD_W:0]   wr_mask;
    logic [CODE_FIELD_W-1:0] wr_code;
    logic [SYM_AW-1:0]       sym_idx;

    // Table
    logic [NUM_SYMBOLS-1:0]  entry_vld_reg;
    logic [ENTRY_W-1:0]      rd_entry;

    // Stage 1
    logic                    s1_valid_reg, s1_valid_next;
    logic [1:0]              s1_op_reg;
    logic                    s1_hit_reg, s1_hit_next;

    // Packer state
    logic [PEND_W-1:0]       pend_reg, pend_next;
    logic [2:0]              cnt_reg, cnt_next;
    logic                    any_reg, any_next;

    // Packer datapath
    logic [LEN_W-1:0]        clen;
    logic [CODE_W-1:0]       ccode;
    logic                    enc_go;
    logic                    flush_go;
    logic [ACC_W-1:0]        acc;
    logic [TOT_W-1:0]        total;
    logic [TOT_W-1:0]        sh0, sh1;
    logic                    ge8, ge16;
    logic [2:0]              new_cnt;
    logic [BYTE_W-1:0]       new_mask;
    logic [BYTE_W-1:0]       pend8;
    logic [BYTE_W-1:0]       flush_byte;
    logic [TAIL_W-1:0]       flush_tail;

    // Queue
    res_push_t               push;
    logic [QAW:0]            q_count;
    logic [QAW+1:0]          q_need;
    result_t                 q_head;

    // Request acceptance and table write decode
    assign q_need       = {1'b0, q_count} + (s1_valid_reg ? (QAW+2)'(2) : '0) + (QAW+2)'(2);
    assign item.ready   = (q_need <= (QAW+2)'(RES_FIFO_DEPTH));
    assign item_acc     = item.valid && item.ready;
    assign sym_in_range = ({1'b0, item.symbol} < NUM_SYM_L);
    assign sym_idx      = item.symbol[SYM_AW-1:0];
    assign wr_ok        = item_acc && (item.op == OP_WRITE) && sym_in_range
                          && (item.code_len <= MAX_LEN_L);
    assign wr_mask      = ((CODE_FIELD_W+1)'(1) << item.code_len) - (CODE_FIELD_W+1)'(1);
    assign wr_code      = item.code_bits & wr_mask[CODE_FIELD_W-1:0];

    hse_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_table (
        .clk   (clk),
        .we    (wr_ok),
        .waddr (sym_idx),
        .wdata ({wr_code[CODE_W-1:0], item.code_len}),
        .raddr (sym_idx),
        .rdata (rd_entry)
    );

    // Entry valid bits: an unwritten entry reads as length zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_vld_reg <= '0;
        end
        else if (wr_ok)
        begin
            entry_vld_reg[sym_idx] <= 1'b1;
        end
    end

    // Stage 1 capture
    always_comb
    begin
        s1_valid_next = item_acc;
        s1_hit_next   = sym_in_range && entry_vld_reg[sym_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            s1_op_reg  <= item.op;
            s1_hit_reg <= s1_hit_next;
        end
    end

    // Code append and byte extraction
    assign clen     = s1_hit_reg ? rd_entry[LEN_W-1:0] : '0;
    assign ccode    = rd_entry[ENTRY_W-1:LEN_W];
    assign enc_go   = s1_valid_reg && (s1_op_reg == OP_ENCODE) && (clen != '0);
    assign flush_go = s1_valid_reg && (s1_op_reg == OP_FLUSH);
    assign acc      = (ACC_W'(pend_reg) << clen) | ACC_W'(ccode);
    assign total    = TOT_W'(cnt_reg) + TOT_W'(clen);
    assign sh0      = total - TOT_W'(8);
    assign sh1      = total - TOT_W'(16);
    assign ge8      = (total >= TOT_W'(8));
    assign ge16     = (total >= TOT_W'(16));
    assign new_cnt  = total[2:0];
    assign new_mask = (BYTE_W'(1) << new_cnt) - BYTE_W'(1);

    // Flush: zero-pad the partial byte
    assign pend8      = {1'b0, pend_reg};
    assign flush_byte = pend8 << (4'd8 - {1'b0, cnt_reg});
    assign flush_tail = (cnt_reg != '0) ? TAIL_W'(cnt_reg)
                      : (any_reg ? TAIL_W'(8) : '0);

    // Results into the queue
    always_comb
    begin
        push = '0;
        if (flush_go)
        begin
            push.valid0          = 1'b1;
            push.res0.out_byte   = (cnt_reg != '0) ? flush_byte : '0;
            push.res0.byte_valid = (cnt_reg != '0);
            push.res0.last       = 1'b1;
            push.res0.tail_bits  = flush_tail;
        end
        else if (enc_go)
        begin
            push.valid0          = ge8;
            push.valid1          = ge16;
            push.res0.out_byte   = BYTE_W'(acc >> sh0);
            push.res0.byte_valid = 1'b1;
            push.res1.out_byte   = BYTE_W'(acc >> sh1);
            push.res1.byte_valid = 1'b1;
        end
    end

    // Pending bits update
    always_comb
    begin
        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        any_next  = any_reg;
        if (flush_go)
        begin
            pend_next = '0;
            cnt_next  = '0;
            any_next  = 1'b0;
        end
        else if (enc_go)
        begin
            pend_next = acc[PEND_W-1:0] & new_mask[PEND_W-1:0];
            cnt_next  = new_cnt;
            any_next  = any_reg || ge8;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            cnt_reg  <= '0;
            any_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
            any_reg  <= any_next;
        end
    end

    hse_result_fifo u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .count     (q_count),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_res   (q_head)
    );

    assign result.out_byte   = q_head.out_byte;
    assign result.byte_valid = q_head.byte_valid;
    assign result.last       = q_head.last;
    assign result.tail_bits  = q_head.tail_bits;

endmodule

/* sv/hse_checker.sv */
// Port-level checks for the encoder, attached to the top level by bind.
`include "assert_macros.svh"

module hse_checker import hse_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input logic [1:0] item_op,
    input logic       result_valid,
    input logic       result_ready,
    input logic [7:0] result_out_byte,
    input logic       result_byte_valid,
    input logic       result_last,
    input logic [3:0] result_tail_bits
);

    // No result is offered while reset is held
    `HSE_ASSERT_ALWAYS(a_quiet_in_reset, clk, !rst_n |-> !result_valid)

    // A stalled result keeps its contents
    `HSE_ASSERT(a_result_hold, clk, rst_n, result_valid && !result_ready |=> result_valid && $stable(result_out_byte) && $stable(result_byte_valid) && $stable(result_last) && $stable(result_tail_bits))

    // Requests are only held off while results are backed up
    `HSE_ASSERT(a_ready_backlog, clk, rst_n, !item_ready |-> result_valid)

    // A flush into an idle block reports end of stream once it has passed stage 1 and the result queue
    `HSE_ASSERT(a_flush_latency, clk, rst_n, $past(!(item_valid && item_ready)) && !result_valid && item_valid && item_ready && item_op == OP_FLUSH |-> ##2 result_valid && result_last)

endmodule

bind huffman_symbol_encoder_packer hse_checker u_hse_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .item_op           (item.op),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_out_byte   (result.out_byte),
    .result_byte_valid (result.byte_valid),
    .result_last       (result.last),
    .result_tail_bits  (result.tail_bits)
);
